// ===== hdl/bsa_pkg.sv =====
// ----------------------------------------------------------------------------
// bsa_pkg
// shared types and codes for the buffer slot allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bsa_pkg;

   localparam int CAP_WIDTH = 40;
   localparam int ID_WIDTH  = 32;

   localparam logic ACTION_ACQUIRE = 1'b0;
   localparam logic ACTION_RELEASE = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // request travelling down the slot chain
   typedef struct packed {
      logic                 valid;
      logic                 action;
      logic [CAP_WIDTH-1:0] want;
      logic [ID_WIDTH-1:0]  rel_id;
      logic [ID_WIDTH-1:0]  fresh_id;
      logic                 done;
      logic                 fresh_taken;
      logic [ID_WIDTH-1:0]  granted_id;
      logic [CAP_WIDTH-1:0] granted_cap;
      logic                 reused;
   } probe_type;

endpackage

`default_nettype wire

// ===== hdl/bsa_cell.sv =====
// ----------------------------------------------------------------------------
// bsa_cell
// one buffer slot: busy mark, capacity and id, checked as a request passes by
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_cell
   import bsa_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire probe_type probe_in,
   output probe_type      probe_out
);

   logic                 busy_ff, busy_in;
   logic [CAP_WIDTH-1:0] cap_ff, cap_in;
   logic [ID_WIDTH-1:0]  id_ff, id_in;
   probe_type            probe_ff, probe_fwd_in;

   logic active;
   logic cap_fits;
   logic cap_fresh;
   logic hit_acquire;
   logic hit_release;

   always_comb begin
      active      = probe_in.valid && !probe_in.done;
      cap_fits    = (cap_ff >= probe_in.want);
      cap_fresh   = (cap_ff == '0);
      hit_acquire = active && (probe_in.action == ACTION_ACQUIRE) && !busy_ff &&
                    (cap_fits || cap_fresh);
      hit_release = active && (probe_in.action == ACTION_RELEASE) && busy_ff &&
                    (id_ff == probe_in.rel_id);

      busy_in      = busy_ff;
      cap_in       = cap_ff;
      id_in        = id_ff;
      probe_fwd_in = probe_in;

      if (hit_acquire) begin
         busy_in           = 1'b1;
         probe_fwd_in.done = 1'b1;
         if (cap_fits) begin
            probe_fwd_in.granted_id  = id_ff;
            probe_fwd_in.granted_cap = cap_ff;
            probe_fwd_in.reused      = 1'b1;
         end else begin
            cap_in                   = probe_in.want;
            id_in                    = probe_in.fresh_id;
            probe_fwd_in.granted_id  = probe_in.fresh_id;
            probe_fwd_in.granted_cap = probe_in.want;
            probe_fwd_in.fresh_taken = 1'b1;
         end
      end else if (hit_release) begin
         busy_in           = 1'b0;
         probe_fwd_in.done = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         cap_ff         <= '0;
         id_ff          <= '0;
         probe_ff.valid <= 1'b0;
      end else begin
         busy_ff        <= busy_in;
         cap_ff         <= cap_in;
         id_ff          <= id_in;
         probe_ff.valid <= probe_fwd_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      probe_ff.action      <= probe_fwd_in.action;
      probe_ff.want        <= probe_fwd_in.want;
      probe_ff.rel_id      <= probe_fwd_in.rel_id;
      probe_ff.fresh_id    <= probe_fwd_in.fresh_id;
      probe_ff.done        <= probe_fwd_in.done;
      probe_ff.fresh_taken <= probe_fwd_in.fresh_taken;
      probe_ff.granted_id  <= probe_fwd_in.granted_id;
      probe_ff.granted_cap <= probe_fwd_in.granted_cap;
      probe_ff.reused      <= probe_fwd_in.reused;
   end

   assign probe_out = probe_ff;

endmodule

`default_nettype wire

// ===== hdl/buffer_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// buffer_slot_allocator
// first-fit buffer slot allocator over a chain of slot cells
// flow: an accepted request walks the slot chain one cell per cycle, and its result
//    is then registered for the response; no new request is accepted until the scan
//    has finished and the previous response has been taken or is being taken
// reset: synchronous; slot table cleared and next id set to one at once
// ----------------------------------------------------------------------------
`default_nettype none

module buffer_slot_allocator
   import bsa_pkg::*;
#(
   parameter int SLOT_COUNT = 16
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // want_bytes[39:0], release_id[71:40]
   input  wire logic [0:0]  req_tuser,   // action[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,   // granted_id[31:0], granted_capacity[71:32],
                                         // reused[72], zero[79:73]
   output logic [0:0]       rsp_tuser    // status[0]
);

   state_type state_ff, state_in;

   logic [ID_WIDTH-1:0]  next_id_ff, next_id_in;
   logic [ID_WIDTH-1:0]  fresh_id;
   logic [ID_WIDTH-1:0]  id_after;
   logic [CAP_WIDTH-1:0] req_want;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_status_ff;
   logic [ID_WIDTH-1:0]  rsp_id_ff;
   logic [CAP_WIDTH-1:0] rsp_cap_ff;
   logic                 rsp_reused_ff;

   logic      req_accept;
   logic      rsp_accept;
   probe_type chain [SLOT_COUNT+1];
   probe_type tail;

   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign tail       = chain[SLOT_COUNT];

   assign fresh_id = (next_id_ff == '0) ? {{(ID_WIDTH-1){1'b0}}, 1'b1} : next_id_ff;
   assign id_after = (fresh_id + ID_WIDTH'(1) == '0) ? {{(ID_WIDTH-1){1'b0}}, 1'b1}
                                                     : fresh_id + ID_WIDTH'(1);
   assign req_want = (req_tdata[39:0] == '0) ? {{(CAP_WIDTH-1){1'b0}}, 1'b1}
                                             : req_tdata[39:0];

   always_comb begin
      chain[0].valid       = req_accept;
      chain[0].action      = req_tuser[0];
      chain[0].want        = req_want;
      chain[0].rel_id      = req_tdata[71:40];
      chain[0].fresh_id    = fresh_id;
      chain[0].done        = 1'b0;
      chain[0].fresh_taken = 1'b0;
      chain[0].granted_id  = '0;
      chain[0].granted_cap = '0;
      chain[0].reused      = 1'b0;
   end

   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
      bsa_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .probe_in  (chain[i]),
         .probe_out (chain[i+1])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (tail.valid) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_tready = !reset && (!rsp_valid_ff || rsp_tready);
         ST_SCAN: req_tready = 1'b0;
         default: req_tready = 1'b0;
      endcase
   end

   always_comb begin
      next_id_in = next_id_ff;
      if (tail.valid && tail.fresh_taken) next_id_in = id_after;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_accept) rsp_valid_in = 1'b0;
      if (tail.valid) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         next_id_ff   <= {{(ID_WIDTH-1){1'b0}}, 1'b1};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tail.valid) begin
         rsp_status_ff <= tail.done ? STATUS_OK : STATUS_FAIL;
         rsp_id_ff     <= tail.granted_id;
         rsp_cap_ff    <= tail.granted_cap;
         rsp_reused_ff <= tail.reused;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {7'b0, rsp_reused_ff, rsp_cap_ff, rsp_id_ff};
   assign rsp_tuser[0] = rsp_status_ff;

   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      tail.valid |-> (state_ff == ST_SCAN))
      else $error("request left the chain outside a scan");

   a_tail_slot_free: assert property (@(posedge clock) disable iff (reset)
      tail.valid |-> !rsp_valid_ff || rsp_tready)
      else $error("response register still full when a scan finished");

   a_next_id_nonzero: assert property (@(posedge clock) disable iff (reset)
      next_id_ff != '0)
      else $error("next id became zero");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0] == STATUS_FAIL) |-> (rsp_tdata == '0))
      else $error("failed response carries nonzero fields");

endmodule

`default_nettype wire
